// ===== rtl/uer_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

  // Register map of the configuration port.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY = 2'd3;

  // Register widths and values after reset.
  localparam int SETTLE_W = 20;
  localparam int TRIGGER_W = 10;
  localparam int TIMEOUT_W = 20;
  localparam int RETRY_W = 4;
  localparam logic [SETTLE_W-1:0] SETTLE_RST = 20'd10000;
  localparam logic [TRIGGER_W-1:0] TRIGGER_RST = 10'd10;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd30000;
  localparam logic [RETRY_W-1:0] RETRY_RST = 4'd1;

  // Distance is round(width * 17 / 1000): tracked as quotient and remainder.
  localparam int DIST_W = 15;
  localparam int REM_W = 10;
  localparam logic [REM_W-1:0] DIST_STEP = 10'd17;
  localparam logic [REM_W-1:0] DIST_DEN = 10'd1000;
  localparam logic [REM_W-1:0] DIST_BIAS = 10'd500;
  localparam logic [DIST_W-1:0] DIST_MAX = 15'd32767;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_SETTLE = 5'b00010,
    PH_TRIG   = 5'b00100,
    PH_RISE   = 5'b01000,
    PH_HIGH   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [SETTLE_W-1:0]  settle;
    logic [TRIGGER_W-1:0] trigger;
    logic [TIMEOUT_W-1:0] timeout;
    logic [RETRY_W-1:0]   retry;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic step;
  } dist_ctl_t;

  typedef struct packed {
    logic              trigger;
    logic              busy;
    logic              done;
    logic              fail;
    logic [DIST_W-1:0] distance;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/uer_dist.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Running distance: each counted echo tick adds 17 to a remainder modulo 1000,
// carrying into a quotient that saturates at the output limit.
module uer_dist (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        fire,
  input  wire uer_pkg::dist_ctl_t          ctl,
  output logic [uer_pkg::DIST_W-1:0]       quot
);

  logic [uer_pkg::REM_W-1:0] rem;
  logic [uer_pkg::REM_W-1:0] rem_sum;
  logic                      carry;

  assign rem_sum = rem + uer_pkg::DIST_STEP;
  assign carry = (rem_sum >= uer_pkg::DIST_DEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      quot <= '0;
      rem <= uer_pkg::DIST_BIAS;
    end else if (fire) begin
      if (ctl.clear) begin
        quot <= '0;
        rem <= uer_pkg::DIST_BIAS;
      end else if (ctl.step) begin
        if (carry) begin
          rem <= rem_sum - uer_pkg::DIST_DEN;
          if (quot != uer_pkg::DIST_MAX) begin
            quot <= quot + 1'b1;
          end
        end else begin
          rem <= rem_sum;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uer_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ranging sequencer: settle, trigger pulse, echo wait and echo timing,
// with retries. Updates its state once for each word that is fired.
module uer_fsm #(
  parameter int COUNTER_BITS = 20
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        fire,
  input  wire logic                        start_req,
  input  wire logic                        echo_level,
  input  wire uer_pkg::cfg_t               cfg,
  input  wire logic [uer_pkg::DIST_W-1:0]  dist_quot,
  output uer_pkg::dist_ctl_t               dist_ctl,
  output uer_pkg::result_t                 result
);

  localparam int CW = (COUNTER_BITS > uer_pkg::SETTLE_W) ? COUNTER_BITS : uer_pkg::SETTLE_W;

  uer_pkg::phase_t                phase, phase_next;
  logic [COUNTER_BITS-1:0]        phase_ticks, phase_ticks_next;
  logic [COUNTER_BITS-1:0]        echo_width, echo_width_next;
  logic [uer_pkg::RETRY_W-1:0]    tries_left, tries_left_next;
  logic [COUNTER_BITS-1:0]        ticks_inc;
  logic [uer_pkg::RETRY_W-1:0]    tries_dec;
  logic                           done, fail, attempt_failed, dist_out;

  // A limit above the counter range is clamped to its top value; since the
  // counter never exceeds that value, reaching it also meets the limit.
  function automatic logic reached(input logic [COUNTER_BITS-1:0] t,
                                   input logic [CW-1:0] lim);
    return (CW'(t) >= lim) || (t == '1);
  endfunction

  assign ticks_inc = (phase_ticks == '1) ? phase_ticks : phase_ticks + 1'b1;
  assign tries_dec = (tries_left != '0) ? tries_left - 1'b1 : tries_left;

  always_comb begin
    phase_next = phase;
    phase_ticks_next = phase_ticks;
    echo_width_next = echo_width;
    tries_left_next = tries_left;
    done = 1'b0;
    fail = 1'b0;
    attempt_failed = 1'b0;
    dist_out = 1'b0;
    dist_ctl = '0;
    case (phase)
      uer_pkg::PH_IDLE: begin
        if (start_req) begin
          if (cfg.retry == '0) begin
            done = 1'b1;
            fail = 1'b1;
          end else begin
            tries_left_next = cfg.retry;
            phase_next = uer_pkg::PH_SETTLE;
            phase_ticks_next = '0;
          end
        end
      end
      uer_pkg::PH_SETTLE: begin
        phase_ticks_next = ticks_inc;
        if (reached(ticks_inc, CW'(cfg.settle))) begin
          phase_next = uer_pkg::PH_TRIG;
          phase_ticks_next = '0;
        end
      end
      uer_pkg::PH_TRIG: begin
        phase_ticks_next = ticks_inc;
        if (reached(ticks_inc, CW'(cfg.trigger))) begin
          phase_next = uer_pkg::PH_RISE;
          phase_ticks_next = '0;
          echo_width_next = '0;
          dist_ctl.clear = 1'b1;
        end
      end
      uer_pkg::PH_RISE, uer_pkg::PH_HIGH: begin
        phase_ticks_next = ticks_inc;
        if (echo_level) begin
          phase_next = uer_pkg::PH_HIGH;
          echo_width_next = (echo_width == '1) ? echo_width : echo_width + 1'b1;
          dist_ctl.step = (echo_width != '1);
          attempt_failed = reached(ticks_inc, CW'(cfg.timeout));
        end else if (phase == uer_pkg::PH_RISE) begin
          attempt_failed = reached(ticks_inc, CW'(cfg.timeout));
        end else begin
          // Echo has fallen: the measurement is complete.
          done = 1'b1;
          dist_out = 1'b1;
          phase_next = uer_pkg::PH_IDLE;
          phase_ticks_next = '0;
        end
      end
      default: begin
        phase_next = uer_pkg::PH_IDLE;
        phase_ticks_next = '0;
      end
    endcase

    // A timed-out attempt either starts again from the settle time or ends
    // the request with a failure.
    if (attempt_failed) begin
      tries_left_next = tries_dec;
      phase_ticks_next = '0;
      if (tries_dec != '0) begin
        phase_next = uer_pkg::PH_SETTLE;
      end else begin
        phase_next = uer_pkg::PH_IDLE;
        done = 1'b1;
        fail = 1'b1;
      end
    end
  end

  always_comb begin
    result.trigger = (phase_next == uer_pkg::PH_TRIG);
    result.busy = (phase_next != uer_pkg::PH_IDLE);
    result.done = done;
    result.fail = fail;
    result.distance = dist_out ? dist_quot : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= uer_pkg::PH_IDLE;
      phase_ticks <= '0;
      echo_width <= '0;
      tries_left <= '0;
    end else if (fire) begin
      phase <= phase_next;
      phase_ticks <= phase_ticks_next;
      echo_width <= echo_width_next;
      tries_left <= tries_left_next;
    end
  end

`ifndef SYNTHESIS
  // Echo timing only ever follows the trigger pulse.
  a_high_from_rise: assert property (@(posedge clk) disable iff (rst)
    fire && (phase_next == uer_pkg::PH_HIGH) && (phase != uer_pkg::PH_HIGH)
      |-> (phase == uer_pkg::PH_RISE))
    else $error("echo timing entered without waiting for the rise");
  // While sequencing an attempt there is always at least one try left.
  a_tries_left: assert property (@(posedge clk) disable iff (rst)
    (phase != uer_pkg::PH_IDLE) |-> (tries_left != '0))
    else $error("attempt in progress with no tries left");
  // A measurement always ends with the sequencer back in idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    fire && done |-> (phase_next == uer_pkg::PH_IDLE))
    else $error("measurement ended outside idle");
`endif

endmodule

`default_nettype wire

// ===== rtl/ultrasonic_echo_ranger_unit.sv =====
// A word accepted on the input is registered in the input stage, and its result word is
// registered in the output stage and offered on the output from there.
// Throughput: one word per clock while the output is taken; the input register and
// the output register form a two-stage pipeline, so one input word is taken while a result waits.
// Reset (rst, synchronous, active high) empties both stages, puts the
// sequencer in idle with counters cleared and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger_unit #(
  parameter int COUNTER_BITS = 20
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [uer_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            start_req,
  input  wire logic                            echo_level,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 trigger_level,
  output logic                                 busy_res,
  output logic                                 done_res,
  output logic                                 failed,
  output logic [uer_pkg::DIST_W-1:0]           distance_cm
);

  uer_pkg::cfg_t       cfg;
  uer_pkg::dist_ctl_t  dist_ctl;
  uer_pkg::result_t    result;
  logic [uer_pkg::DIST_W-1:0] dist_quot;
  logic s1_valid, s1_start, s1_echo;
  logic advance, fire;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle <= uer_pkg::SETTLE_RST;
      cfg.trigger <= uer_pkg::TRIGGER_RST;
      cfg.timeout <= uer_pkg::TIMEOUT_RST;
      cfg.retry <= uer_pkg::RETRY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        uer_pkg::CFG_SETTLE:  cfg.settle <= cfg_wr_data[uer_pkg::SETTLE_W-1:0];
        uer_pkg::CFG_TRIGGER: cfg.trigger <= cfg_wr_data[uer_pkg::TRIGGER_W-1:0];
        uer_pkg::CFG_TIMEOUT: cfg.timeout <= cfg_wr_data[uer_pkg::TIMEOUT_W-1:0];
        uer_pkg::CFG_RETRY:   cfg.retry <= cfg_wr_data[uer_pkg::RETRY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow: the output stage advances when empty or taken.
  assign advance = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign fire = s1_valid && advance;

  // Input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_start <= start_req;
      s1_echo <= echo_level;
    end
  end

  uer_fsm #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_fsm (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .start_req  (s1_start),
    .echo_level (s1_echo),
    .cfg        (cfg),
    .dist_quot  (dist_quot),
    .dist_ctl   (dist_ctl),
    .result     (result)
  );

  uer_dist u_dist (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .ctl  (dist_ctl),
    .quot (dist_quot)
  );

  // Output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      trigger_level <= result.trigger;
      busy_res <= result.busy;
      done_res <= result.done;
      failed <= result.fail;
      distance_cm <= result.distance;
    end
  end

`ifndef SYNTHESIS
  // A failure is only reported together with the end of a measurement.
  a_fail_with_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && failed |-> done_res)
    else $error("failure flagged without done");
  // A distance is only given on a successful completion.
  a_dist_on_success: assert property (@(posedge clk) disable iff (rst)
    out_valid && (distance_cm != '0) |-> (done_res && !failed))
    else $error("distance shown outside a successful completion");
  // The trigger is only driven during a measurement.
  a_trigger_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && trigger_level |-> busy_res)
    else $error("trigger high while not busy");
  // A held input word stays in the input stage until it moves on.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_start) && $stable(s1_echo))
    else $error("input stage lost a stalled word");
`endif

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  // Counters saturate at the width the unit is built with.
  localparam int COUNT_BITS = 20;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // How the echo pin behaves once the trigger pulse has ended.
  typedef enum int {
    ECHO_PULSE,
    ECHO_SILENT,
    ECHO_STUCK,
    ECHO_NOISE
  } echo_kind_t;

  typedef logic [uer_pkg::CFG_DATA_W-1:0] cfg_word_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_wr_en;
  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wr_data;
  logic                           in_valid;
  logic                           in_ready;
  logic                           start_req;
  logic                           echo_level;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           trigger_level;
  logic                           busy_res;
  logic                           done_res;
  logic                           failed;
  logic [uer_pkg::DIST_W-1:0]     distance_cm;

  // Shadow copy of the registers and of the ranging sequencer.
  logic [uer_pkg::SETTLE_W-1:0]   settle_set;
  logic [uer_pkg::TRIGGER_W-1:0]  trigger_set;
  logic [uer_pkg::TIMEOUT_W-1:0]  timeout_set;
  logic [uer_pkg::RETRY_W-1:0]    retry_set;
  uer_pkg::phase_t                rng_phase;
  logic [COUNT_BITS-1:0]          rng_ticks;
  logic [COUNT_BITS-1:0]          rng_echo_w;
  logic [uer_pkg::RETRY_W-1:0]    rng_tries;

  uer_pkg::result_t predicted_readings[$];
  int      mismatch_count = 0;
  int      checked_words = 0;
  int      ranging_words = 0;
  int      burst_left = 0;
  int      rx_left = 0;
  int      rx_mode = 0;

  ultrasonic_echo_ranger_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_req    (start_req),
    .echo_level   (echo_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .trigger_level(trigger_level),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .failed       (failed),
    .distance_cm  (distance_cm)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  task automatic reset_shadow();
    settle_set  = uer_pkg::SETTLE_RST;
    trigger_set = uer_pkg::TRIGGER_RST;
    timeout_set = uer_pkg::TIMEOUT_RST;
    retry_set   = uer_pkg::RETRY_RST;
    rng_phase   = uer_pkg::PH_IDLE;
    rng_ticks   = '0;
    rng_echo_w  = '0;
    rng_tries   = '0;
  endtask

  // Advance the shadow sequencer by one microsecond tick and return the result
  // word that tick produces. No register is wider than the counters, so the
  // clamp against the counter maximum never changes a register value.
  function automatic uer_pkg::result_t advance_ranger(input logic start_bit,
                                                      input logic echo_bit);
    uer_pkg::result_t r;
    logic             attempt_lost;
    logic [31:0]      scaled;
    r = '0;
    attempt_lost = 1'b0;
    case (rng_phase)
      uer_pkg::PH_IDLE: begin
        if (start_bit) begin
          if (retry_set == '0) begin
            r.done = 1'b1;
            r.fail = 1'b1;
          end else begin
            rng_tries = retry_set;
            rng_phase = uer_pkg::PH_SETTLE;
            rng_ticks = '0;
          end
        end
      end
      uer_pkg::PH_SETTLE: begin
        rng_ticks = sat_inc(rng_ticks);
        if (32'(rng_ticks) >= 32'(settle_set)) begin
          rng_phase = uer_pkg::PH_TRIG;
          rng_ticks = '0;
        end
      end
      uer_pkg::PH_TRIG: begin
        rng_ticks = sat_inc(rng_ticks);
        if (32'(rng_ticks) >= 32'(trigger_set)) begin
          rng_phase  = uer_pkg::PH_RISE;
          rng_ticks  = '0;
          rng_echo_w = '0;
        end
      end
      uer_pkg::PH_RISE, uer_pkg::PH_HIGH: begin
        rng_ticks = sat_inc(rng_ticks);
        if (echo_bit) begin
          rng_phase  = uer_pkg::PH_HIGH;
          rng_echo_w = sat_inc(rng_echo_w);
          if (32'(rng_ticks) >= 32'(timeout_set)) attempt_lost = 1'b1;
        end else if (rng_phase == uer_pkg::PH_RISE) begin
          if (32'(rng_ticks) >= 32'(timeout_set)) attempt_lost = 1'b1;
        end else begin
          // Falling edge: convert the echo width with rounding, halves up.
          scaled = (32'(rng_echo_w) * 32'(uer_pkg::DIST_STEP) + 32'(uer_pkg::DIST_BIAS))
                   / 32'(uer_pkg::DIST_DEN);
          r.distance = (scaled > 32'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX
                                                         : scaled[uer_pkg::DIST_W-1:0];
          r.done = 1'b1;
          rng_phase = uer_pkg::PH_IDLE;
          rng_ticks = '0;
        end
      end
      default: begin
        rng_phase = uer_pkg::PH_IDLE;
        rng_ticks = '0;
      end
    endcase

    // A lost attempt either goes round again or ends the request as failed.
    if (attempt_lost) begin
      if (rng_tries != '0) rng_tries = rng_tries - 1'b1;
      rng_ticks = '0;
      if (rng_tries != '0) begin
        rng_phase = uer_pkg::PH_SETTLE;
      end else begin
        rng_phase = uer_pkg::PH_IDLE;
        r.done = 1'b1;
        r.fail = 1'b1;
      end
    end

    r.trigger = (rng_phase == uer_pkg::PH_TRIG);
    r.busy    = (rng_phase != uer_pkg::PH_IDLE);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= 30) begin
      $display("[%0t] %s wrong on result word %0d: got %0d, expected %0d",
               $time, what, checked_words, got, want);
    end
  endtask

  // Offer one word, with bursts of random length and random gaps between them.
  task automatic send_word(input logic start_bit, input logic echo_bit);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    start_req  <= start_bit;
    echo_level <= echo_bit;
    do @(posedge clk); while (!in_ready);
    predicted_readings.push_back(advance_ranger(start_bit, echo_bit));
    burst_left--;
  endtask

  // Drop valid and hold off until every predicted word has come back.
  task automatic settle_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (predicted_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                                input logic [uer_pkg::CFG_DATA_W-1:0] data);
    settle_pipeline();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    case (idx)
      uer_pkg::CFG_SETTLE:  settle_set  = data[uer_pkg::SETTLE_W-1:0];
      uer_pkg::CFG_TRIGGER: trigger_set = data[uer_pkg::TRIGGER_W-1:0];
      uer_pkg::CFG_TIMEOUT: timeout_set = data[uer_pkg::TIMEOUT_W-1:0];
      uer_pkg::CFG_RETRY:   retry_set   = data[uer_pkg::RETRY_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Words with random pins, for the settle and trigger phases where echo is ignored.
  task automatic send_ticks(input int count);
    logic s;
    logic e;
    repeat (count) begin
      s = 1'($urandom_range(0, 1));
      e = 1'($urandom_range(0, 1));
      send_word(s, e);
    end
  endtask

  // Keep ticking until the request in progress has ended. The echo follows
  // the chosen shape, counted from the end of the trigger pulse in each attempt.
  task automatic run_ranging(input int delay, input int width, input echo_kind_t kind,
                             input logic hold_start);
    int   upcoming;
    logic echo_bit;
    logic start_bit;
    while (rng_phase != uer_pkg::PH_IDLE) begin
      upcoming = int'(rng_ticks) + 1;
      if (rng_phase == uer_pkg::PH_SETTLE || rng_phase == uer_pkg::PH_TRIG) begin
        echo_bit = 1'($urandom_range(0, 1));
      end else begin
        case (kind)
          ECHO_PULSE:  echo_bit = (upcoming > delay) && (upcoming <= delay + width);
          ECHO_SILENT: echo_bit = 1'b0;
          ECHO_STUCK:  echo_bit = (upcoming > delay);
          default:     echo_bit = 1'($urandom_range(0, 1));
        endcase
      end
      start_bit = hold_start ? 1'b1 : 1'($urandom_range(0, 1));
      // Now and then the sender waits for the output side to catch up.
      if ($urandom_range(0, 59) == 0) settle_pipeline();
      send_word(start_bit, echo_bit);
      ranging_words++;
    end
  endtask

  task automatic request_reading(input int delay, input int width, input echo_kind_t kind);
    logic e;
    e = 1'($urandom_range(0, 1));
    send_word(1'b1, e);
    ranging_words++;
    run_ranging(delay, width, kind, 1'b0);
  endtask

  // Settle and trigger values at both ends of their ranges and the largest timeout, changed in mid-measurement.
  task automatic test_register_extremes();
    send_word(1'b1, 1'b0);
    send_ticks(5);
    write_register(uer_pkg::CFG_SETTLE, 20'hFFFFF);
    send_ticks(3);
    write_register(uer_pkg::CFG_TRIGGER, 20'h003FF);
    write_register(uer_pkg::CFG_TIMEOUT, 20'hFFFFF);
    write_register(uer_pkg::CFG_SETTLE, 20'h00000);
    send_ticks(5);
    write_register(uer_pkg::CFG_TRIGGER, 20'h00000);
    run_ranging(4, 40, ECHO_PULSE, 1'b0);
  endtask

  // No attempts allowed: the request fails on the spot and the unit stays idle.
  task automatic test_zero_attempts();
    write_register(uer_pkg::CFG_RETRY, 20'h00000);
    send_word(1'b1, 1'b0);
    send_word(1'b1, 1'b1);
    send_word(1'b0, 1'b1);
    write_register(uer_pkg::CFG_RETRY, 20'h00001);
  endtask

  // Zero settle and trigger still last a tick; zero timeout loses the first tick.
  task automatic test_zero_durations();
    write_register(uer_pkg::CFG_SETTLE, 20'h00000);
    write_register(uer_pkg::CFG_TRIGGER, 20'h00000);
    write_register(uer_pkg::CFG_TIMEOUT, 20'h00000);
    request_reading(0, 3, ECHO_SILENT);
    request_reading(0, 3, ECHO_STUCK);
  endtask

  // An echo that falls on the timeout tick succeeds; one still high there fails.
  task automatic test_timeout_edge();
    write_register(uer_pkg::CFG_SETTLE, 20'h00001);
    write_register(uer_pkg::CFG_TRIGGER, 20'h00001);
    write_register(uer_pkg::CFG_TIMEOUT, 20'h00006);
    request_reading(1, 4, ECHO_PULSE);
    request_reading(1, 5, ECHO_PULSE);
  endtask

  // The largest retry count, every attempt lost.
  task automatic test_retry_exhaustion();
    write_register(uer_pkg::CFG_SETTLE, 20'h00000);
    write_register(uer_pkg::CFG_TRIGGER, 20'h00001);
    write_register(uer_pkg::CFG_TIMEOUT, 20'h00001);
    write_register(uer_pkg::CFG_RETRY, 20'h0000F);
    request_reading(0, 1, ECHO_SILENT);
    write_register(uer_pkg::CFG_TIMEOUT, 20'h00004);
    write_register(uer_pkg::CFG_RETRY, 20'h00003);
    request_reading(2, 9, ECHO_STUCK);
  endtask

  // A request held on the tick a measurement ends is dropped; the next one starts.
  task automatic test_start_at_completion();
    write_register(uer_pkg::CFG_TIMEOUT, 20'h00014);
    write_register(uer_pkg::CFG_RETRY, 20'h00002);
    send_word(1'b1, 1'b0);
    run_ranging(2, 6, ECHO_PULSE, 1'b1);
    send_word(1'b1, 1'b0);
    run_ranging(3, 5, ECHO_PULSE, 1'b1);
  endtask

  task automatic randomise_registers();
    cfg_word_t                     junk;
    logic [uer_pkg::TRIGGER_W-1:0] trig_pick;
    logic [uer_pkg::RETRY_W-1:0]   retry_pick;
    int                            roll;
    junk = cfg_word_t'($urandom);
    write_register(uer_pkg::CFG_SETTLE,
                   cfg_word_t'(($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                           : $urandom_range(0, 8)));
    roll = $urandom_range(0, 6);
    trig_pick = roll[uer_pkg::TRIGGER_W-1:0];
    write_register(uer_pkg::CFG_TRIGGER,
                   {junk[uer_pkg::CFG_DATA_W-1:uer_pkg::TRIGGER_W], trig_pick});
    roll = $urandom_range(0, 19);
    retry_pick = (roll == 0) ? 4'd0 : (roll == 1) ? 4'd15 : 4'($urandom_range(1, 4));
    write_register(uer_pkg::CFG_RETRY,
                   {junk[uer_pkg::CFG_DATA_W-1:uer_pkg::RETRY_W], retry_pick});
    // Many attempts get a short timeout so that a hopeless echo ends soon.
    if (retry_pick > 4'd4) begin
      write_register(uer_pkg::CFG_TIMEOUT, cfg_word_t'($urandom_range(1, 10)));
    end else begin
      write_register(uer_pkg::CFG_TIMEOUT,
                     cfg_word_t'(($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, 70)));
    end
  endtask

  // Mostly clean echo pulses of random delay and width, with silent, stuck
  // and noisy echoes mixed in, and idle words between requests.
  task automatic test_random_ranging();
    int         delay;
    int         width;
    int         roll;
    echo_kind_t kind;
    logic       e;
    while (ranging_words < 550) begin
      if ($urandom_range(0, 2) == 0) randomise_registers();
      repeat ($urandom_range(0, 2)) begin
        e = 1'($urandom_range(0, 1));
        send_word(1'b0, e);
      end
      roll = $urandom_range(0, 99);
      kind = (roll < 72) ? ECHO_PULSE : (roll < 82) ? ECHO_SILENT :
             (roll < 92) ? ECHO_STUCK : ECHO_NOISE;
      delay = $urandom_range(0, 12);
      width = ($urandom_range(0, 19) == 0) ? $urandom_range(120, 300) : $urandom_range(1, 45);
      // A long echo gets a clean pulse and a timeout that lets it finish.
      if (width > 100) begin
        kind = ECHO_PULSE;
        write_register(uer_pkg::CFG_TIMEOUT,
                       cfg_word_t'(delay + width + $urandom_range(1, 40)));
      end
      request_reading(delay, width, kind);
      // The long timeout is not left in place for the requests that follow.
      if (width > 100) begin
        write_register(uer_pkg::CFG_TIMEOUT, cfg_word_t'($urandom_range(1, 10)));
      end
    end
  endtask

  // Output side: random stall patterns, each held for a randomly drawn run before the next is picked.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 4);
      rx_left <= $urandom_range(5, 60);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= (rx_left % 4 != 0);
      3:       out_ready <= (rx_left % 16 == 0);
      default: out_ready <= 1'b1;
    endcase
  end

  // Compare each word taken from the output with the oldest prediction.
  always @(posedge clk) begin
    uer_pkg::result_t got;
    uer_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{trigger_level, busy_res, done_res, failed, distance_cm};
      if (predicted_readings.size() == 0) begin
        flag_mismatch("unpredicted word", 1, 0);
      end else begin
        want = predicted_readings.pop_front();
        if (got.trigger !== want.trigger)
          flag_mismatch("trigger_level", int'(got.trigger), int'(want.trigger));
        if (got.busy !== want.busy)
          flag_mismatch("busy_res", int'(got.busy), int'(want.busy));
        if (got.done !== want.done)
          flag_mismatch("done_res", int'(got.done), int'(want.done));
        if (got.fail !== want.fail)
          flag_mismatch("failed", int'(got.fail), int'(want.fail));
        if (got.distance !== want.distance)
          flag_mismatch("distance_cm", int'(got.distance), int'(want.distance));
      end
      checked_words++;
    end
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_index   = uer_pkg::CFG_SETTLE;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    start_req   = 1'b0;
    echo_level  = 1'b0;
    reset_shadow();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_extremes();
    test_zero_attempts();
    test_zero_durations();
    test_timeout_edge();
    test_retry_exhaustion();
    test_start_at_completion();
    test_random_ranging();

    settle_pipeline();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/uer_pkg.sv
rtl/uer_dist.sv
rtl/uer_fsm.sv
rtl/ultrasonic_echo_ranger_unit.sv
verif/testbench.sv
